// ===== src/mflg_pkg.sv =====
// ----------------------------------------------------------------------------
// mflg_pkg
// Request codes, result status codes, register indexes and fixed field widths
// shared by the max-flow level-graph core and its checker.
// ----------------------------------------------------------------------------
package mflg_pkg;

   localparam int NODE_W   = 7;
   localparam int CAP_W    = 32;
   localparam int FLOW_W   = 42;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FLOW  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] STS_STORED    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FLOW_DONE = 3'd2;
   localparam logic [STATUS_W-1:0] STS_SAME_NODE = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CLEARED   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 1'b1;

   localparam logic [CAP_W-1:0] PUSH_CAP = 32'h3f3f3f3f;

endpackage

// ===== src/max_flow_level_graph_core.sv =====
// ----------------------------------------------------------------------------
// max_flow_level_graph_core
// Dinic maximum-flow engine over an edge store in on-chip memories.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_type, req_from_node, req_to_node,
//                                        req_capacity
//   rsp      out  rsp_valid/rsp_ready    rsp_status, rsp_max_flow
//   csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// An add writes the forward arc and then the reverse arc, a clear sweeps the node
// list heads, and an unused code is dropped with no response. A compute runs, per
// phase, a level clearing sweep and a level build over reached nodes and scanned
// arcs, then a push walk over arc steps with credits.
// After reset the node list heads are swept with req_ready low.
// A new item is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module max_flow_level_graph_core #(
   parameter int MAX_NODES = 128,
   parameter int MAX_EDGES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mflg_pkg::REQ_W-1:0]          req_type,
   input  logic [mflg_pkg::NODE_W-1:0]         req_from_node,
   input  logic [mflg_pkg::NODE_W-1:0]         req_to_node,
   input  logic [mflg_pkg::CAP_W-1:0]          req_capacity,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mflg_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mflg_pkg::FLOW_W-1:0]         rsp_max_flow,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mflg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mflg_pkg::NODE_W-1:0]         csr_wdata
);

   localparam int ARC_SLOTS = 2 * MAX_EDGES;
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DW = NW + 1;
   localparam int LW = NW + 1;
   localparam int PW = $clog2(ARC_SLOTS);
   localparam int AW = $clog2(ARC_SLOTS + 1);
   localparam int CW = mflg_pkg::CAP_W;
   localparam int FW = mflg_pkg::FLOW_W;
   localparam int RAW_NODES = 1 << mflg_pkg::NODE_W;

   localparam logic [AW-1:0] ARC_NIL  = AW'(ARC_SLOTS);
   localparam logic [LW-1:0] LVL_NONE = '1;
   localparam logic [LW-1:0] LVL_DEAD = LVL_NONE - LW'(1);

   localparam logic [4:0] ST_INIT   = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_ADD1   = 5'd2;
   localparam logic [4:0] ST_ADD2   = 5'd3;
   localparam logic [4:0] ST_DONE   = 5'd4;
   localparam logic [4:0] ST_LCLR   = 5'd5;
   localparam logic [4:0] ST_BSEED  = 5'd6;
   localparam logic [4:0] ST_BPOP   = 5'd7;
   localparam logic [4:0] ST_BPOP1  = 5'd8;
   localparam logic [4:0] ST_BPOP2  = 5'd9;
   localparam logic [4:0] ST_BARC   = 5'd10;
   localparam logic [4:0] ST_BARC1  = 5'd11;
   localparam logic [4:0] ST_BARC2  = 5'd12;
   localparam logic [4:0] ST_BEND   = 5'd13;
   localparam logic [4:0] ST_BEND1  = 5'd14;
   localparam logic [4:0] ST_PSTART = 5'd15;
   localparam logic [4:0] ST_PSTRT1 = 5'd16;
   localparam logic [4:0] ST_PSTEP  = 5'd17;
   localparam logic [4:0] ST_PARC1  = 5'd18;
   localparam logic [4:0] ST_PARC2  = 5'd19;
   localparam logic [4:0] ST_CRED0  = 5'd20;
   localparam logic [4:0] ST_CRED1  = 5'd21;
   localparam logic [4:0] ST_POP    = 5'd22;
   localparam logic [4:0] ST_PPOP1  = 5'd23;
   localparam logic [4:0] ST_PPOP2  = 5'd24;

   typedef struct packed {
      logic [NW-1:0] target;
      logic [PW-1:0] partner;
      logic [CW-1:0] residual;
      logic [AW-1:0] next;
   } arc_type;

   typedef struct packed {
      logic [NW-1:0] node;
      logic [AW-1:0] arc;
      logic [CW-1:0] lim;
      logic [CW-1:0] sum;
      logic [LW-1:0] lv;
   } frame_type;

   logic [NW-1:0] node_tbl [RAW_NODES];

   for (genvar g = 0; g < RAW_NODES; g++) begin : g_node_tbl
      assign node_tbl[g] = NW'(g % MAX_NODES);
   end

   arc_type   arc_mem   [ARC_SLOTS];
   logic [AW-1:0] first_mem [MAX_NODES];
   logic [LW-1:0] level_mem [MAX_NODES];
   frame_type frame_mem [MAX_NODES];

   logic          arc_we;
   logic [PW-1:0] arc_waddr, arc_raddr;
   arc_type       arc_wdata, arc_rdata;
   logic          first_we;
   logic [NW-1:0] first_waddr, first_raddr;
   logic [AW-1:0] first_wdata, first_rdata;
   logic          level_we;
   logic [NW-1:0] level_waddr, level_raddr;
   logic [LW-1:0] level_wdata, level_rdata;
   logic          frame_we;
   logic [NW-1:0] frame_waddr, frame_raddr;
   frame_type     frame_wdata, frame_rdata;

   logic [4:0]    state_ff, state_in;
   logic [NW-1:0] sweep_ff, sweep_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [NW-1:0] u_ff, u_in, v_ff, v_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] acnt_ff, acnt_in;
   logic [mflg_pkg::NODE_W-1:0] src_ff, snk_ff;
   logic [DW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] a_ff, a_in;
   arc_type       arcd_ff, arcd_in;
   logic [NW-1:0] node_ff, node_in;
   logic [CW-1:0] lim_ff, lim_in, sum_ff, sum_in, got_ff, got_in;
   logic [LW-1:0] lv_ff, lv_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [FW-1:0] flow_ff, flow_in;
   logic [mflg_pkg::STATUS_W-1:0] res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [mflg_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FW-1:0] rsp_flow_ff, rsp_flow_in;

   logic [NW-1:0] s_node, t_node;
   logic [AW:0]   acnt_plus2;
   logic [CW-1:0] lim_new;
   logic [DW-1:0] depth_m1, depth_m2;

   assign s_node     = node_tbl[src_ff];
   assign t_node     = node_tbl[snk_ff];
   assign acnt_plus2 = {1'b0, acnt_ff} + (AW+1)'(2);
   assign lim_new    = (arcd_ff.residual < lim_ff) ? arcd_ff.residual : lim_ff;
   assign depth_m1   = depth_ff - DW'(1);
   assign depth_m2   = depth_ff - DW'(2);

   always_ff @(posedge clock) begin
      if (arc_we) begin
         arc_mem[arc_waddr] <= arc_wdata;
      end
      arc_rdata <= arc_mem[arc_raddr];
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_waddr] <= first_wdata;
      end
      first_rdata <= first_mem[first_raddr];
   end

   always_ff @(posedge clock) begin
      if (level_we) begin
         level_mem[level_waddr] <= level_wdata;
      end
      level_rdata <= level_mem[level_raddr];
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      frame_rdata <= frame_mem[frame_raddr];
   end

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      clr_rsp_in  = clr_rsp_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      cap_in      = cap_ff;
      acnt_in     = acnt_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      a_in        = a_ff;
      arcd_in     = arcd_ff;
      node_in     = node_ff;
      lim_in      = lim_ff;
      sum_in      = sum_ff;
      got_in      = got_ff;
      lv_in       = lv_ff;
      depth_in    = depth_ff;
      flow_in     = flow_ff;
      res_in      = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_flow_in   = rsp_flow_ff;
      arc_we      = 1'b0;
      arc_waddr   = a_ff[PW-1:0];
      arc_wdata   = arcd_ff;
      arc_raddr   = a_ff[PW-1:0];
      first_we    = 1'b0;
      first_waddr = sweep_ff;
      first_wdata = ARC_NIL;
      first_raddr = s_node;
      level_we    = 1'b0;
      level_waddr = sweep_ff;
      level_wdata = LVL_NONE;
      level_raddr = t_node;
      frame_we    = 1'b0;
      frame_waddr = depth_m1[NW-1:0];
      frame_wdata = '0;
      frame_raddr = head_ff[NW-1:0];

      case (state_ff)
         ST_INIT: begin
            first_we = 1'b1;
            if (sweep_ff == NW'(MAX_NODES - 1)) begin
               acnt_in = '0;
               if (clr_rsp_ff) begin
                  clr_rsp_in = 1'b0;
                  res_in     = mflg_pkg::STS_CLEARED;
                  flow_in    = '0;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + NW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               flow_in = '0;
               case (req_type)
                  mflg_pkg::REQ_ADD: begin
                     u_in        = node_tbl[req_from_node];
                     v_in        = node_tbl[req_to_node];
                     cap_in      = req_capacity;
                     first_raddr = node_tbl[req_from_node];
                     if (acnt_plus2 > (AW+1)'(ARC_SLOTS)) begin
                        res_in   = mflg_pkg::STS_FULL;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_ADD1;
                     end
                  end
                  mflg_pkg::REQ_FLOW: begin
                     if (s_node == t_node) begin
                        res_in   = mflg_pkg::STS_SAME_NODE;
                        state_in = ST_DONE;
                     end else begin
                        sweep_in = '0;
                        state_in = ST_LCLR;
                     end
                  end
                  mflg_pkg::REQ_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_INIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD1: begin
            arc_we             = 1'b1;
            arc_waddr          = acnt_ff[PW-1:0];
            arc_wdata.target   = v_ff;
            arc_wdata.partner  = PW'(acnt_ff + AW'(1));
            arc_wdata.residual = cap_ff;
            arc_wdata.next     = first_rdata;
            first_we           = 1'b1;
            first_waddr        = u_ff;
            first_wdata        = acnt_ff;
            first_raddr        = v_ff;
            state_in           = ST_ADD2;
         end
         ST_ADD2: begin
            arc_we             = 1'b1;
            arc_waddr          = PW'(acnt_ff + AW'(1));
            arc_wdata.target   = u_ff;
            arc_wdata.partner  = acnt_ff[PW-1:0];
            arc_wdata.residual = '0;
            arc_wdata.next     = (u_ff == v_ff) ? acnt_ff : first_rdata;
            first_we           = 1'b1;
            first_waddr        = v_ff;
            first_wdata        = acnt_ff + AW'(1);
            acnt_in            = acnt_plus2[AW-1:0];
            res_in             = mflg_pkg::STS_STORED;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ff;
               rsp_flow_in   = flow_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_LCLR: begin
            level_we = 1'b1;
            if (sweep_ff == NW'(MAX_NODES - 1)) begin
               state_in = ST_BSEED;
            end else begin
               sweep_in = sweep_ff + NW'(1);
            end
         end
         ST_BSEED: begin
            level_we         = 1'b1;
            level_waddr      = s_node;
            level_wdata      = '0;
            frame_we         = 1'b1;
            frame_waddr      = '0;
            frame_wdata.node = s_node;
            head_in          = '0;
            tail_in          = DW'(1);
            state_in         = ST_BPOP;
         end
         ST_BPOP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_BEND;
            end else begin
               head_in  = head_ff + DW'(1);
               state_in = ST_BPOP1;
            end
         end
         ST_BPOP1: begin
            first_raddr = frame_rdata.node;
            level_raddr = frame_rdata.node;
            state_in    = ST_BPOP2;
         end
         ST_BPOP2: begin
            a_in     = first_rdata;
            lv_in    = level_rdata;
            state_in = ST_BARC;
         end
         ST_BARC: begin
            state_in = (a_ff >= ARC_NIL) ? ST_BPOP : ST_BARC1;
         end
         ST_BARC1: begin
            arcd_in     = arc_rdata;
            level_raddr = arc_rdata.target;
            state_in    = ST_BARC2;
         end
         ST_BARC2: begin
            if (arcd_ff.residual != '0 && level_rdata == LVL_NONE &&
                tail_ff < DW'(MAX_NODES)) begin
               level_we         = 1'b1;
               level_waddr      = arcd_ff.target;
               level_wdata      = lv_ff + LW'(1);
               frame_we         = 1'b1;
               frame_waddr      = tail_ff[NW-1:0];
               frame_wdata.node = arcd_ff.target;
               tail_in          = tail_ff + DW'(1);
            end
            a_in     = arcd_ff.next;
            state_in = ST_BARC;
         end
         ST_BEND: begin
            state_in = ST_BEND1;
         end
         ST_BEND1: begin
            if (level_rdata == LVL_NONE) begin
               res_in   = mflg_pkg::STS_FLOW_DONE;
               state_in = ST_DONE;
            end else begin
               state_in = ST_PSTART;
            end
         end
         ST_PSTART: begin
            state_in = ST_PSTRT1;
         end
         ST_PSTRT1: begin
            node_in  = s_node;
            lim_in   = mflg_pkg::PUSH_CAP;
            sum_in   = '0;
            lv_in    = '0;
            a_in     = first_rdata;
            depth_in = DW'(1);
            state_in = ST_PSTEP;
         end
         ST_PSTEP: begin
            state_in = (a_ff >= ARC_NIL) ? ST_POP : ST_PARC1;
         end
         ST_PARC1: begin
            arcd_in     = arc_rdata;
            level_raddr = arc_rdata.target;
            first_raddr = arc_rdata.target;
            state_in    = ST_PARC2;
         end
         ST_PARC2: begin
            if (arcd_ff.residual != '0 && level_rdata == lv_ff + LW'(1)) begin
               if (arcd_ff.target == t_node || lim_new == '0) begin
                  got_in   = lim_new;
                  state_in = ST_CRED0;
               end else if (depth_ff >= DW'(MAX_NODES)) begin
                  got_in   = '0;
                  state_in = ST_CRED0;
               end else begin
                  frame_we         = 1'b1;
                  frame_wdata.node = node_ff;
                  frame_wdata.arc  = a_ff;
                  frame_wdata.lim  = lim_ff;
                  frame_wdata.sum  = sum_ff;
                  frame_wdata.lv   = lv_ff;
                  node_in  = arcd_ff.target;
                  lim_in   = lim_new;
                  sum_in   = '0;
                  lv_in    = level_rdata;
                  a_in     = first_rdata;
                  depth_in = depth_ff + DW'(1);
                  state_in = ST_PSTEP;
               end
            end else begin
               a_in     = arcd_ff.next;
               state_in = ST_PSTEP;
            end
         end
         ST_CRED0: begin
            arc_we             = 1'b1;
            arc_wdata.residual = arcd_ff.residual - got_ff;
            arc_raddr          = arcd_ff.partner;
            sum_in             = sum_ff + got_ff;
            lim_in             = lim_ff - got_ff;
            a_in               = arcd_ff.next;
            state_in           = ST_CRED1;
         end
         ST_CRED1: begin
            arc_we             = 1'b1;
            arc_waddr          = arcd_ff.partner;
            arc_wdata          = arc_rdata;
            arc_wdata.residual = arc_rdata.residual + got_ff;
            state_in           = ST_PSTEP;
         end
         ST_POP: begin
            got_in = sum_ff;
            if (sum_ff == '0) begin
               level_we    = 1'b1;
               level_waddr = node_ff;
               level_wdata = LVL_DEAD;
            end
            if (depth_ff == DW'(1)) begin
               if (sum_ff != '0) begin
                  flow_in  = flow_ff + FW'(sum_ff);
                  state_in = ST_PSTART;
               end else begin
                  sweep_in = '0;
                  state_in = ST_LCLR;
               end
            end else begin
               frame_raddr = depth_m2[NW-1:0];
               depth_in    = depth_m1;
               state_in    = ST_PPOP1;
            end
         end
         ST_PPOP1: begin
            node_in   = frame_rdata.node;
            a_in      = frame_rdata.arc;
            lim_in    = frame_rdata.lim;
            sum_in    = frame_rdata.sum;
            lv_in     = frame_rdata.lv;
            arc_raddr = frame_rdata.arc[PW-1:0];
            state_in  = ST_PPOP2;
         end
         ST_PPOP2: begin
            arcd_in  = arc_rdata;
            state_in = ST_CRED0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         acnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         src_ff       <= '0;
         snk_ff       <= mflg_pkg::NODE_W'(1);
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         acnt_ff      <= acnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == mflg_pkg::CSR_SOURCE) begin
               src_ff <= csr_wdata;
            end else begin
               snk_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff          <= u_in;
      v_ff          <= v_in;
      cap_ff        <= cap_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      a_ff          <= a_in;
      arcd_ff       <= arcd_in;
      node_ff       <= node_in;
      lim_ff        <= lim_in;
      sum_ff        <= sum_in;
      got_ff        <= got_in;
      lv_ff         <= lv_in;
      depth_ff      <= depth_in;
      flow_ff       <= flow_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_flow_ff   <= rsp_flow_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_max_flow = rsp_flow_ff;

endmodule

// ===== src/mflg_checker.sv =====
// ----------------------------------------------------------------------------
// mflg_checker
// Port-level checks for the max-flow level-graph core, bound to its top level.
// ----------------------------------------------------------------------------
module mflg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [mflg_pkg::REQ_W-1:0]          req_type,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mflg_pkg::STATUS_W-1:0]       rsp_status,
   input logic [mflg_pkg::FLOW_W-1:0]         rsp_max_flow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_max_flow))
      else $error("rsp item changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != mflg_pkg::REQ_NONE |=> !req_ready)
      else $error("req_ready stayed high after a working item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= mflg_pkg::STS_CLEARED)
      else $error("rsp_status out of range");

   a_flow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mflg_pkg::STS_FLOW_DONE |-> rsp_max_flow == '0)
      else $error("rsp_max_flow nonzero without a flow result");

endmodule

bind max_flow_level_graph_core mflg_checker u_mflg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_type     (req_type),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_max_flow (rsp_max_flow)
);
